@@ rtl/idea_pkg.sv @@
// ----------------------------------------------------------------------------
// IDEA cipher package
// Shared types, constants and arithmetic helpers for the IDEA block cipher.
// ----------------------------------------------------------------------------
package idea_pkg;

  localparam int NUM_SUBKEYS = 52;
  localparam int NUM_ROUNDS  = 8;
  localparam int NUM_INV     = 18;
  localparam int INV_STEPS   = 16;
  localparam int LAST_PHASE  = 2;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;

  typedef enum logic [2:0] {
    ST_INV_LOAD,
    ST_INV_RUN,
    ST_INV_STORE,
    ST_IDLE,
    ST_ROUND
  } state_t;

  typedef struct packed {
    logic       inv_load;
    logic       inv_step;
    logic       inv_store;
    logic [4:0] inv_idx;
    logic       blk_load;
    logic       blk_run;
    logic [3:0] round;
    logic [1:0] phase;
  } dp_cmd_t;

  // Multiplication mod 65537 where zero stands for 65536.
  function automatic logic [15:0] mul_mod(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [16:0] r;
    p = 32'(a) * 32'(b);
    r = {1'b0, p[15:0]} - {1'b0, p[31:16]};
    if (r[16]) begin
      r = r + 17'h10001;
    end
    if (a == 16'd0) begin
      return 16'd1 - b;
    end else if (b == 16'd0) begin
      return 16'd1 - a;
    end
    return r[15:0];
  endfunction

  function automatic logic [15:0] neg_mod(input logic [15:0] x);
    return 16'd0 - x;
  endfunction

  // Encryption subkey n: word n mod 8 of the key rotated left by 25 per group.
  function automatic logic [15:0] enc_subkey(input logic [127:0] k, input int n);
    logic [127:0] rk;
    int r;
    r  = (25 * (n / 8)) % 128;
    rk = (k << r) | (k >> (128 - r));
    return rk[127 - 16 * (n % 8) -: 16];
  endfunction

endpackage

@@ rtl/idea_ctrl.sv @@
// ----------------------------------------------------------------------------
// IDEA controller
// Sequences the decryption key inversions and the rounds of one block.
// ----------------------------------------------------------------------------
module idea_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  output logic             busy,
  output idea_pkg::dp_cmd_t cmd
);
  import idea_pkg::*;

  state_t     state, state_next;
  logic [4:0] inv_idx, inv_idx_next;
  logic [3:0] inv_cnt, inv_cnt_next;
  logic [3:0] round, round_next;
  logic [1:0] phase, phase_next;
  logic       key_write;

  assign key_write = cfg_we && (cfg_addr == REG_KEY_HIGH || cfg_addr == REG_KEY_LOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INV_LOAD;
      inv_idx <= '0;
      inv_cnt <= '0;
      round   <= '0;
      phase   <= '0;
    end else begin
      state   <= state_next;
      inv_idx <= inv_idx_next;
      inv_cnt <= inv_cnt_next;
      round   <= round_next;
      phase   <= phase_next;
    end
  end

  always_comb begin
    state_next   = state;
    inv_idx_next = inv_idx;
    inv_cnt_next = inv_cnt;
    round_next   = round;
    phase_next   = phase;
    cmd          = '0;
    cmd.inv_idx  = inv_idx;
    cmd.round    = round;
    cmd.phase    = phase;
    unique case (state)
      ST_INV_LOAD: begin
        cmd.inv_load = 1'b1;
        inv_cnt_next = '0;
        state_next   = ST_INV_RUN;
      end
      ST_INV_RUN: begin
        cmd.inv_step = 1'b1;
        inv_cnt_next = inv_cnt + 4'd1;
        if (inv_cnt == 4'(INV_STEPS - 1)) begin
          state_next = ST_INV_STORE;
        end
      end
      ST_INV_STORE: begin
        cmd.inv_store = 1'b1;
        if (inv_idx == 5'(NUM_INV - 1)) begin
          state_next = ST_IDLE;
        end else begin
          inv_idx_next = inv_idx + 5'd1;
          state_next   = ST_INV_LOAD;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.blk_load = 1'b1;
          round_next   = '0;
          phase_next   = '0;
          state_next   = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.blk_run = 1'b1;
        if (round == 4'(NUM_ROUNDS)) begin
          state_next = ST_IDLE;
        end else if (phase == 2'(LAST_PHASE)) begin
          phase_next = '0;
          round_next = round + 4'd1;
        end else begin
          phase_next = phase + 2'd1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // A new key restarts the inversion sweep.
    if (key_write) begin
      inv_idx_next = '0;
      state_next   = ST_INV_LOAD;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ rtl/idea_dp.sv @@
// ----------------------------------------------------------------------------
// IDEA datapath
// Key registers, subkey inversion unit, inverse store and the round unit.
// ----------------------------------------------------------------------------
module idea_dp (
  input  logic              clk,
  input  logic              rst,
  input  idea_pkg::dp_cmd_t cmd,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [63:0]       cfg_data,
  input  logic              func,
  input  logic [63:0]       block_in,
  output logic [63:0]       block_out,
  output logic              done
);
  import idea_pkg::*;

  logic [63:0] key_high, key_low;
  logic [15:0] enc [NUM_SUBKEYS];
  logic [31:0] inv_mem [NUM_ROUNDS + 1];
  logic [15:0] inv_src, acc, base;
  logic [15:0] rk [6];
  logic        func_r;
  logic [15:0] x1, x2, x3, x4, t0;
  logic [15:0] t1, t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_KEY_HIGH) begin
        key_high <= cfg_data;
      end else if (cfg_addr == REG_KEY_LOW) begin
        key_low <= cfg_data;
      end
    end
  end

  // Encryption subkeys are pure wiring of the key.
  always_comb begin
    for (int n = 0; n < NUM_SUBKEYS; n++) begin
      enc[n] = enc_subkey({key_high, key_low}, n);
    end
  end

  // Even entries invert the round's first subkey, odd ones its fourth.
  always_comb begin
    inv_src = '0;
    for (int i = 0; i < NUM_INV; i++) begin
      if (cmd.inv_idx == 5'(i)) begin
        inv_src = enc[48 - 6 * (i / 2) + 3 * (i % 2)];
      end
    end
  end

  // Inverse is x to the power 65535, one square-and-multiply per cycle.
  always_ff @(posedge clk) begin
    if (cmd.inv_load) begin
      acc  <= 16'd1;
      base <= inv_src;
    end else if (cmd.inv_step) begin
      acc  <= mul_mod(acc, base);
      base <= mul_mod(base, base);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.inv_store) begin
      if (cmd.inv_idx[0]) begin
        inv_mem[cmd.inv_idx[4:1]][15:0] <= acc;
      end else begin
        inv_mem[cmd.inv_idx[4:1]][31:16] <= acc;
      end
    end
  end

  // Round key selection for the current round and direction.
  always_comb begin
    int  s;
    logic mid;
    for (int j = 0; j < 6; j++) begin
      rk[j] = '0;
    end
    s   = 0;
    mid = 1'b0;
    for (int r = 0; r <= NUM_ROUNDS; r++) begin
      if (cmd.round == 4'(r)) begin
        if (!func_r) begin
          for (int j = 0; j < 6; j++) begin
            if (6 * r + j < NUM_SUBKEYS) begin
              rk[j] = enc[6 * r + j];
            end
          end
        end else begin
          s   = 48 - 6 * r;
          // The first decryption round and the output transform keep the
          // additive keys in order; the middle rounds swap them.
          mid = (r == 0 || r == NUM_ROUNDS);
          rk[0] = inv_mem[r][31:16];
          rk[1] = neg_mod(enc[mid ? s + 1 : s + 2]);
          rk[2] = neg_mod(enc[mid ? s + 2 : s + 1]);
          rk[3] = inv_mem[r][15:0];
          if (r < NUM_ROUNDS) begin
            rk[4] = enc[(r < NUM_ROUNDS) ? s - 2 : 0];
            rk[5] = enc[(r < NUM_ROUNDS) ? s - 1 : 0];
          end
        end
      end
    end
  end

  assign t1 = mul_mod(t0 + (x2 ^ x4), rk[5]);
  assign t2 = t0 + t1;

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      func_r <= func;
      x1     <= block_in[63:48];
      x2     <= block_in[47:32];
      x3     <= block_in[31:16];
      x4     <= block_in[15:0];
    end else if (cmd.blk_run) begin
      if (cmd.round == 4'(NUM_ROUNDS)) begin
        block_out <= {mul_mod(x1, rk[0]), x3 + rk[1], x2 + rk[2], mul_mod(x4, rk[3])};
      end else begin
        case (cmd.phase)
          2'd0: begin
            x1 <= mul_mod(x1, rk[0]);
            x2 <= x2 + rk[1];
            x3 <= x3 + rk[2];
            x4 <= mul_mod(x4, rk[3]);
          end
          2'd1: begin
            t0 <= mul_mod(x1 ^ x3, rk[4]);
          end
          default: begin
            x1 <= x1 ^ t1;
            x4 <= x4 ^ t2;
            x2 <= x3 ^ t1;
            x3 <= x2 ^ t2;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.blk_run && (cmd.round == 4'(NUM_ROUNDS));
    end
  end

endmodule

@@ rtl/idea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// IDEA block cipher
// Encrypts or decrypts one 64-bit block with a 128-bit key (8.5 rounds).
// ----------------------------------------------------------------------------
// Once start is taken, the block is loaded and each of the eight rounds runs
// through the shared round unit (key add and multiply, MA multiply, then mix
// and swap); the output stage then registers block_out and done together.
// Each block is finished before the next is taken; the next start is taken
// while done is high. After reset and after each key write, busy stays high
// while the unit computes 18 inverses, each a load, 16 steps and a store.
module idea_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] block_in,
  output logic [63:0] block_out,
  output logic        done,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [63:0] cfg_data
);
  import idea_pkg::*;

  dp_cmd_t cmd;

  idea_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .busy     (busy),
    .cmd      (cmd)
  );

  idea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .func      (func),
    .block_in  (block_in),
    .block_out (block_out),
    .done      (done)
  );

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !cfg_we) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe lasted more than one cycle");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result delivered while still busy");

  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_addr == REG_KEY_HIGH || cfg_addr == REG_KEY_LOW)) |=> busy)
    else $error("key write did not start the key schedule");

endmodule

@@ tb/tb_idea_block_cipher.sv @@
// ----------------------------------------------------------------------------
// IDEA block cipher testbench
// Drives blocks in both directions under many keys. A predictor built into
// the bench checks every output block, with random gaps between transactions.
// ----------------------------------------------------------------------------
module tb_idea_block_cipher;
  timeunit 1ns;
  timeprecision 1ps;

  import idea_pkg::*;

  localparam logic [1:0] REG_SPARE  = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic       FUNC_ENC  = 1'b0;
  localparam logic       FUNC_DEC  = 1'b1;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         DRAIN_CYCLES   = 40;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        func;
  logic [63:0] block_in;
  logic [63:0] block_out;
  logic        done;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [63:0] cfg_data;

  logic [63:0] key_hi_q;
  logic [63:0] key_lo_q;
  logic [15:0] enc_keys [NUM_SUBKEYS];
  logic [15:0] dec_keys [NUM_SUBKEYS];
  logic [63:0] pending_blocks [$];
  int          errors;
  int          idle_cycles = 0;
  int          gap_pct;

  idea_block_cipher i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .block_in(block_in), .block_out(block_out), .done(done),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Multiplication mod 65537, the zero word standing for 65536.
  function automatic logic [15:0] mulm(input logic [15:0] a, input logic [15:0] b);
    logic [31:0] p;
    logic [31:0] r;
    if (a == 16'd0) return 16'(32'h10001 - 32'(b));
    if (b == 16'd0) return 16'(32'h10001 - 32'(a));
    p = 32'(a) * 32'(b);
    r = 32'(p[15:0]) - 32'(p[31:16]);
    if (r[31:16] != 16'd0) r = r + 32'h10001;
    return r[15:0];
  endfunction

  function automatic logic [15:0] invm(input logic [15:0] x);
    logic [15:0] acc;
    logic [15:0] base;
    acc  = 16'd1;
    base = x;
    for (int i = 0; i < 16; i++) begin
      acc  = mulm(acc, base);
      base = mulm(base, base);
    end
    return acc;
  endfunction

  task automatic derive_subkeys();
    logic [15:0] w [8];
    logic [15:0] nw [8];
    int n;
    int s;
    n = 0;
    for (int i = 0; i < 4; i++) begin
      w[i]     = key_hi_q[63 - 16 * i -: 16];
      w[i + 4] = key_lo_q[63 - 16 * i -: 16];
    end
    while (n < NUM_SUBKEYS) begin
      for (int i = 0; i < 8 && n < NUM_SUBKEYS; i++) begin
        enc_keys[n] = w[i];
        n++;
      end
      for (int j = 0; j < 8; j++) nw[j] = {w[(j + 1) % 8][6:0], w[(j + 2) % 8][15:7]};
      w = nw;
    end
    dec_keys[0] = invm(enc_keys[48]);
    dec_keys[1] = 16'd0 - enc_keys[49];
    dec_keys[2] = 16'd0 - enc_keys[50];
    dec_keys[3] = invm(enc_keys[51]);
    dec_keys[4] = enc_keys[46];
    dec_keys[5] = enc_keys[47];
    for (int i = 1; i < 8; i++) begin
      s = 48 - 6 * i;
      dec_keys[6 * i]     = invm(enc_keys[s]);
      dec_keys[6 * i + 1] = 16'd0 - enc_keys[s + 2];
      dec_keys[6 * i + 2] = 16'd0 - enc_keys[s + 1];
      dec_keys[6 * i + 3] = invm(enc_keys[s + 3]);
      dec_keys[6 * i + 4] = enc_keys[s - 2];
      dec_keys[6 * i + 5] = enc_keys[s - 1];
    end
    dec_keys[48] = invm(enc_keys[0]);
    dec_keys[49] = 16'd0 - enc_keys[1];
    dec_keys[50] = 16'd0 - enc_keys[2];
    dec_keys[51] = invm(enc_keys[3]);
  endtask

  function automatic logic [63:0] cipher_block(input logic dir, input logic [63:0] b);
    logic [15:0] k [NUM_SUBKEYS];
    logic [15:0] x1, x2, x3, x4, t0, t1, t2, y2, y3;
    if (dir == FUNC_ENC) k = enc_keys;
    else k = dec_keys;
    x1 = b[63:48];
    x2 = b[47:32];
    x3 = b[31:16];
    x4 = b[15:0];
    for (int r = 0; r < NUM_ROUNDS; r++) begin
      x1 = mulm(x1, k[6 * r]);
      x2 = x2 + k[6 * r + 1];
      x3 = x3 + k[6 * r + 2];
      x4 = mulm(x4, k[6 * r + 3]);
      t0 = mulm(x1 ^ x3, k[6 * r + 4]);
      t1 = mulm(t0 + (x2 ^ x4), k[6 * r + 5]);
      t2 = t0 + t1;
      x1 = x1 ^ t1;
      x4 = x4 ^ t2;
      y2 = x3 ^ t1;
      y3 = x2 ^ t2;
      x2 = y2;
      x3 = y3;
    end
    return {mulm(x1, k[48]), 16'(x3 + k[49]), 16'(x2 + k[50]), mulm(x4, k[51])};
  endfunction

  task automatic report(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Words near the multiply's special values show up often.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] pick_block();
    return {pick_word(), pick_word(), pick_word(), pick_word()};
  endfunction

  function automatic logic [63:0] pick_key_half();
    if ($urandom_range(0, 3) == 0) return {pick_word(), pick_word(), pick_word(), pick_word()};
    return {$urandom, $urandom};
  endfunction

  task automatic wait_idle();
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we   = 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = value;
    if (idx == REG_KEY_LOW)  key_lo_q = value;
    if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW) derive_subkeys();
  endtask

  task automatic set_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(REG_KEY_HIGH, hi);
    write_reg(REG_KEY_LOW, lo);
  endtask

  // Start stays high from one transaction to the next unless a gap is drawn.
  // Gaps can outlast the busy period so the block also sees an idle sender.
  task automatic send_block(input logic dir, input logic [63:0] b);
    if (!start) @(negedge clk);
    start    = 1'b1;
    func     = dir;
    block_in = b;
    do @(posedge clk); while (busy);
    pending_blocks.push_back(cipher_block(dir, b));
    @(negedge clk);
    if ($urandom_range(1, 100) <= gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(0, 40)) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    start = 1'b0;
  endtask

  task automatic test_reset_key();
    gap_pct = 0;
    send_block(FUNC_ENC, 64'h0);
    send_block(FUNC_DEC, 64'h0);
    send_block(FUNC_ENC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(FUNC_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
    stop_sending();
  endtask

  task automatic test_directed_keys();
    gap_pct = 0;
    set_key(64'h0001_0002_0003_0004, 64'h0005_0006_0007_0008);
    send_block(FUNC_ENC, 64'h0000_0001_0002_0003);
    send_block(FUNC_DEC, 64'h11FB_ED2B_0198_6DE5);
    send_block(FUNC_ENC, 64'h0001_0000_FFFF_0001);
    stop_sending();
    set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(FUNC_ENC, 64'h0);
    send_block(FUNC_DEC, 64'hFFFF_FFFF_FFFF_FFFF);
    send_block(FUNC_ENC, 64'h8000_0000_0000_0001);
    stop_sending();
    // Subkeys of zero and one exercise the inverse special cases.
    set_key(64'h0001_0000_0001_0000, 64'h0000_0001_0000_0001);
    send_block(FUNC_ENC, 64'h0123_4567_89AB_CDEF);
    send_block(FUNC_DEC, 64'hFEDC_BA98_7654_3210);
    stop_sending();
  endtask

  task automatic test_spare_index();
    gap_pct = 0;
    write_reg(REG_SPARE, 64'hDEAD_BEEF_CAFE_F00D);
    write_reg(REG_UNUSED, 64'h1234_5678_9ABC_DEF0);
    send_block(FUNC_ENC, 64'h5555_AAAA_5555_AAAA);
    send_block(FUNC_DEC, 64'hAAAA_5555_AAAA_5555);
    stop_sending();
  endtask

  task automatic test_random(input int pct, input int count);
    gap_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 80 == 0) begin
        stop_sending();
        if ($urandom_range(0, 2) == 0) write_reg(REG_KEY_HIGH, pick_key_half());
        else set_key(pick_key_half(), pick_key_half());
      end
      send_block(1'($urandom), pick_block());
    end
    stop_sending();
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_blocks.size() == 0) begin
        report($sformatf("unexpected block_out %h", block_out));
      end else if (block_out !== pending_blocks[0]) begin
        report($sformatf("block_out %h, predicted %h", block_out, pending_blocks[0]));
        void'(pending_blocks.pop_front());
      end else begin
        void'(pending_blocks.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy) || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ENC;
    block_in = 64'h0;
    cfg_we = 1'b0;
    cfg_addr = REG_KEY_HIGH;
    cfg_data = 64'h0;
    errors = 0;
    gap_pct = 0;
    key_hi_q = 64'h0;
    key_lo_q = 64'h0;
    derive_subkeys();
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_reset_key();
    test_directed_keys();
    test_spare_index();
    test_random(0, 320);
    test_random(60, 320);
    test_random(18, 320);
    test_random(0, 320);
    wait_idle();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
